/* rtl/gcd_pkg.sv */
`timescale 1ns / 1ps
package gcd_pkg;

  localparam int CW = 34;
  typedef logic signed [CW-1:0] cw_t;

  typedef enum logic [1:0] {
    OP_FULL = 2'd0,
    OP_LAT  = 2'd1,
    OP_LON  = 2'd2
  } op_t;

  localparam logic [CW-1:0] CORDIC_GAIN = 34'd652032874;
  localparam logic [30:0]   Q30_ONE     = 31'd1073741824;
  localparam logic [32:0]   DIST_SCALE  = 33'd6588397317;
  localparam logic [34:0]   DIST_MAX    = 35'h7_FFFF_FFFF;
  localparam logic [30:0]   DEG_SCALE   = 31'd1800000000;
  // floor(2^63 / DEG_SCALE): quotient estimate is low by at most one
  localparam logic [32:0]   TURN_RECIP  = 33'd5124095576;
  localparam logic [23:0]   RADIUS_RST  = 24'd6378137;

  // atan(2^-i) as a fraction of a turn, 2^32 per turn
  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] v;
    case (i)
      0: v = 32'd536870912;
      1: v = 32'd316933406;
      2: v = 32'd167458907;
      3: v = 32'd85004756;
      4: v = 32'd42667331;
      5: v = 32'd21354465;
      6: v = 32'd10679838;
      7: v = 32'd5340245;
      8: v = 32'd2670163;
      9: v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      28: v = 32'd3;
      29: v = 32'd1;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/great_circle_distance_core.sv */
`timescale 1ns / 1ps
// Haversine great-circle distance, fully pipelined.
//
// Input word: in_op plus two points (lat/lon in 1e-7 degree). A word is taken
// at each rising edge with start high and busy low; busy is always low, so a
// new word may enter every cycle (one result per cycle sustained).
// Result word: out_distance_mm, shown for exactly one cycle with out_valid
// high. From the accepting edge, each word passes through the two CORDIC
// chains and the 31-step root. The receiver cannot stall; results flow out
// in input order.
// Configuration: cfg_sphere_radius_m is written when cfg_valid is high
// (cfg_ready is always high). Write it only while no word is in flight.
// Reset (rst_n low, synchronous) drops every word in flight and restores the
// radius to 6378137 m.
// Stages: turn conversion (3), fold (1), rotation CORDIC x4 lanes, products
// (2), clamp of a into the root entry, two 31-step square roots, vectoring
// CORDIC, clamp of z, distance scaling (3).
module great_circle_distance_core #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_op,
  input  logic signed [30:0]  in_first_lat,
  input  logic signed [31:0]  in_first_lon,
  input  logic signed [30:0]  in_second_lat,
  input  logic signed [31:0]  in_second_lon,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [23:0]         cfg_sphere_radius_m,
  output logic                out_valid,
  output logic [34:0]         out_distance_mm
);
  import gcd_pkg::*;

  localparam int S   = CORDIC_STAGES;
  localparam int LAT = 42 + 2 * S;
  localparam int SQN = 31;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Radius register
  logic [23:0] radius_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
    end else if (cfg_valid) begin
      radius_r <= cfg_sphere_radius_m;
    end
  end

  // Valid bits travel alongside the data
  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start & ~busy};
    end
  end
  assign out_valid = vld_r[LAT-1];

  // ---------------------------------------------------------------------
  // Turn conversion: t = floor(|x| * 2^31 / 1.8e9), negated for negative x.
  // Lanes: 0 first_lat, 1 first_lon, 2 second_lat, 3 second_lon.
  // ---------------------------------------------------------------------
  logic [31:0] raw [4];
  assign raw[0] = {in_first_lat[30], in_first_lat};
  assign raw[1] = in_first_lon;
  assign raw[2] = {in_second_lat[30], in_second_lat};
  assign raw[3] = in_second_lon;

  logic [31:0] mag1_r [4];
  logic [31:0] q01_r  [4];
  logic        neg1_r [4];
  logic [31:0] rem2_r [4];
  logic [31:0] q02_r  [4];
  logic        neg2_r [4];
  logic [31:0] turn3_r [4];
  logic [1:0]  op1_r, op2_r, op3_r;

  always_ff @(posedge clk) begin
    op1_r <= in_op;
    op2_r <= op1_r;
    op3_r <= op2_r;
  end

  for (genvar l = 0; l < 4; l++) begin : g_turn
    logic [31:0] mag_nxt;
    logic [64:0] est_nxt;
    logic [63:0] qc_nxt;
    logic [63:0] diff_nxt;
    logic [31:0] q_nxt;

    always_comb begin
      mag_nxt  = raw[l][31] ? (32'd0 - raw[l]) : raw[l];
      est_nxt  = {33'd0, mag_nxt} * {32'd0, TURN_RECIP};
      qc_nxt   = {32'd0, q01_r[l]} * {33'd0, DEG_SCALE};
      diff_nxt = {1'b0, mag1_r[l], 31'd0} - qc_nxt;
      q_nxt    = q02_r[l] + {31'd0, (rem2_r[l] >= {1'b0, DEG_SCALE})};
    end

    always_ff @(posedge clk) begin
      mag1_r[l]  <= mag_nxt;
      q01_r[l]   <= est_nxt[63:32];
      neg1_r[l]  <= raw[l][31];
      rem2_r[l]  <= diff_nxt[31:0];
      q02_r[l]   <= q01_r[l];
      neg2_r[l]  <= neg1_r[l];
      turn3_r[l] <= neg2_r[l] ? (32'd0 - q_nxt) : q_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Rotation CORDIC. Lanes: 0 half lat diff, 1 first lat, 2 second lat,
  // 3 half lon diff. Fold the angle into a quarter turn either side of zero;
  // the fold flips the sign of both outputs.
  // ---------------------------------------------------------------------
  logic [31:0] ang [4];
  logic [31:0] dlat_nxt, dlon_nxt;
  assign dlat_nxt = turn3_r[2] - turn3_r[0];
  assign dlon_nxt = turn3_r[3] - turn3_r[1];
  assign ang[0] = {1'b0, dlat_nxt[31:1]};
  assign ang[1] = turn3_r[0];
  assign ang[2] = turn3_r[2];
  assign ang[3] = {1'b0, dlon_nxt[31:1]};

  cw_t        rx_r   [4][S+1];
  cw_t        ry_r   [4][S+1];
  cw_t        rz_r   [4][S+1];
  logic       rneg_r [4][S+1];
  logic [1:0] rop_r  [S+1];

  always_ff @(posedge clk) begin
    rop_r[0] <= op3_r;
  end

  for (genvar l = 0; l < 4; l++) begin : g_rot
    logic [31:0] wrap_nxt;
    logic [31:0] fold_nxt;
    assign wrap_nxt = ang[l] + 32'h4000_0000;
    assign fold_nxt = wrap_nxt[31] ? (ang[l] + 32'h8000_0000) : ang[l];

    always_ff @(posedge clk) begin
      rx_r[l][0]   <= $signed(CORDIC_GAIN);
      ry_r[l][0]   <= '0;
      rz_r[l][0]   <= $signed({{(CW-32){fold_nxt[31]}}, fold_nxt});
      rneg_r[l][0] <= wrap_nxt[31];
    end

    for (genvar i = 0; i < S; i++) begin : g_stage
      cw_t atan_v;
      assign atan_v = $signed({{(CW-32){1'b0}}, atan_turn(i)});
      always_ff @(posedge clk) begin
        rneg_r[l][i+1] <= rneg_r[l][i];
        if (!rz_r[l][i][CW-1]) begin
          rx_r[l][i+1] <= rx_r[l][i] - (ry_r[l][i] >>> i);
          ry_r[l][i+1] <= ry_r[l][i] + (rx_r[l][i] >>> i);
          rz_r[l][i+1] <= rz_r[l][i] - atan_v;
        end else begin
          rx_r[l][i+1] <= rx_r[l][i] + (ry_r[l][i] >>> i);
          ry_r[l][i+1] <= ry_r[l][i] - (rx_r[l][i] >>> i);
          rz_r[l][i+1] <= rz_r[l][i] + atan_v;
        end
      end
    end
  end

  for (genvar i = 0; i < S; i++) begin : g_rop
    always_ff @(posedge clk) begin
      rop_r[i+1] <= rop_r[i];
    end
  end

  // ---------------------------------------------------------------------
  // Haversine terms. Squares ignore the fold sign; the cosine product
  // takes it into account.
  // ---------------------------------------------------------------------
  cw_t c1_nxt, c2_nxt;
  logic signed [67:0] ss_nxt, cc_nxt, ll_nxt, lon_nxt;
  cw_t ss_r, cc_r, ll_r, lat_r, lon_r;
  logic [1:0] op_p1_r, op_p2_r;

  always_comb begin
    c1_nxt  = rneg_r[1][S] ? -rx_r[1][S] : rx_r[1][S];
    c2_nxt  = rneg_r[2][S] ? -rx_r[2][S] : rx_r[2][S];
    ss_nxt  = ry_r[0][S] * ry_r[0][S];
    cc_nxt  = c1_nxt * c2_nxt;
    ll_nxt  = ry_r[3][S] * ry_r[3][S];
    lon_nxt = cc_r * ll_r;
  end

  always_ff @(posedge clk) begin
    ss_r    <= $signed(ss_nxt[63:30]);
    cc_r    <= $signed(cc_nxt[63:30]);
    ll_r    <= $signed(ll_nxt[63:30]);
    op_p1_r <= rop_r[S];
    lat_r   <= ss_r;
    lon_r   <= $signed(lon_nxt[63:30]);
    op_p2_r <= op_p1_r;
  end

  // Select the mode and clamp a to [0, 1] in Q30
  logic signed [CW:0] asum_nxt;
  logic [30:0]        a_nxt;
  always_comb begin
    case (op_p2_r)
      OP_LAT:  asum_nxt = {lat_r[CW-1], lat_r};
      OP_LON:  asum_nxt = {lon_r[CW-1], lon_r};
      default: asum_nxt = {lat_r[CW-1], lat_r} + {lon_r[CW-1], lon_r};
    endcase
    if (asum_nxt[CW]) begin
      a_nxt = '0;
    end else if (asum_nxt > $signed({{(CW-30){1'b0}}, Q30_ONE})) begin
      a_nxt = Q30_ONE;
    end else begin
      a_nxt = asum_nxt[30:0];
    end
  end

  // ---------------------------------------------------------------------
  // Square roots, one result bit per stage. Lane 0 sqrt(a), lane 1 sqrt(1-a).
  // ---------------------------------------------------------------------
  logic [61:0] sv_r    [2][SQN+1];
  logic [32:0] srem_r  [2][SQN+1];
  logic [30:0] sroot_r [2][SQN+1];

  always_ff @(posedge clk) begin
    sv_r[0][0]    <= {1'b0, a_nxt, 30'd0};
    sv_r[1][0]    <= {1'b0, Q30_ONE - a_nxt, 30'd0};
    srem_r[0][0]  <= '0;
    srem_r[1][0]  <= '0;
    sroot_r[0][0] <= '0;
    sroot_r[1][0] <= '0;
  end

  for (genvar l = 0; l < 2; l++) begin : g_sqrt
    for (genvar k = 0; k < SQN; k++) begin : g_step
      logic [34:0] cur_nxt, trial_nxt, diff_nxt;
      always_comb begin
        cur_nxt   = {srem_r[l][k], sv_r[l][k][61-2*k -: 2]};
        trial_nxt = {2'b00, sroot_r[l][k], 2'b01};
        diff_nxt  = cur_nxt - trial_nxt;
      end
      always_ff @(posedge clk) begin
        sv_r[l][k+1] <= sv_r[l][k];
        if (cur_nxt >= trial_nxt) begin
          srem_r[l][k+1]  <= diff_nxt[32:0];
          sroot_r[l][k+1] <= {sroot_r[l][k][29:0], 1'b1};
        end else begin
          srem_r[l][k+1]  <= cur_nxt[32:0];
          sroot_r[l][k+1] <= {sroot_r[l][k][29:0], 1'b0};
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Vectoring CORDIC: z accumulates half the central angle.
  // ---------------------------------------------------------------------
  cw_t vx [S+1];
  cw_t vy [S+1];
  cw_t vz [S+1];
  assign vx[0] = $signed({{(CW-31){1'b0}}, sroot_r[1][SQN]});
  assign vy[0] = $signed({{(CW-31){1'b0}}, sroot_r[0][SQN]});
  assign vz[0] = '0;

  for (genvar i = 0; i < S; i++) begin : g_vec
    cw_t vx_r, vy_r, vz_r, atan_v;
    assign atan_v = $signed({{(CW-32){1'b0}}, atan_turn(i)});
    always_ff @(posedge clk) begin
      if (!vy[i][CW-1]) begin
        vx_r <= vx[i] + (vy[i] >>> i);
        vy_r <= vy[i] - (vx[i] >>> i);
        vz_r <= vz[i] + atan_v;
      end else begin
        vx_r <= vx[i] - (vy[i] >>> i);
        vy_r <= vy[i] + (vx[i] >>> i);
        vz_r <= vz[i] - atan_v;
      end
    end
    assign vx[i+1] = vx_r;
    assign vy[i+1] = vy_r;
    assign vz[i+1] = vz_r;
  end

  // Clamp z to [0, quarter turn]
  logic [30:0] zc_r;
  always_ff @(posedge clk) begin
    if (vz[S][CW-1]) begin
      zc_r <= '0;
    end else if (vz[S] > $signed({{(CW-30){1'b0}}, Q30_ONE})) begin
      zc_r <= Q30_ONE;
    end else begin
      zc_r <= vz[S][30:0];
    end
  end

  // ---------------------------------------------------------------------
  // Distance: floor(z * M * R / 2^51), split into 32-bit halves of z*M.
  // ---------------------------------------------------------------------
  logic [63:0] t_r;
  logic [55:0] ph_r;
  logic [23:0] pl_r;
  logic [63:0] pl_nxt;
  logic [56:0] hi_nxt;

  always_comb begin
    pl_nxt = {32'd0, t_r[31:0]} * {40'd0, radius_r};
    hi_nxt = {1'b0, ph_r} + {33'd0, pl_r};
  end

  always_ff @(posedge clk) begin
    t_r  <= {33'd0, zc_r} * {31'd0, DIST_SCALE};
    ph_r <= {24'd0, t_r[63:32]} * {32'd0, radius_r};
    pl_r <= pl_nxt[55:32];
    // saturate at the field maximum
    if (hi_nxt[56:54] != 3'd0) begin
      out_distance_mm <= DIST_MAX;
    end else begin
      out_distance_mm <= hi_nxt[53:19];
    end
  end

endmodule

/* test/tb_great_circle_distance_core.sv */
`timescale 1ns / 1ps
module tb_great_circle_distance_core;
  import gcd_pkg::*;

  localparam int STAGES = 24;
  localparam int LATENCY = 42 + 2 * STAGES;
  localparam int WATCHDOG_LIMIT = 20 * LATENCY;
  // the fourth op code has no name in the package; it must act as full distance
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam longint Q30 = 64'sd1073741824;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_op = OP_FULL;
  logic signed [30:0] in_first_lat = '0;
  logic signed [31:0] in_first_lon = '0;
  logic signed [30:0] in_second_lat = '0;
  logic signed [31:0] in_second_lon = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [23:0] cfg_sphere_radius_m = '0;
  logic out_valid;
  logic [34:0] out_distance_mm;

  great_circle_distance_core #(.CORDIC_STAGES(STAGES)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_first_lat(in_first_lat), .in_first_lon(in_first_lon),
    .in_second_lat(in_second_lat), .in_second_lon(in_second_lon),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_sphere_radius_m(cfg_sphere_radius_m),
    .out_valid(out_valid), .out_distance_mm(out_distance_mm)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: the radius register as the block should hold it
  longint unsigned radius_m = 64'd6378137;
  logic [34:0] distance_queue[$];
  int error_count = 0;
  int words_sent = 0;
  int words_checked = 0;
  int idle_pct = 0;
  int idle_cycles = 0;

  // arctangent of 2^-i in turn units, 2^32 per turn
  longint atan_lut[32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
    5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0
  };

  // 1e-7 degree to a fraction of a turn, truncated on the magnitude
  function automatic logic [31:0] deg_to_turn(longint x);
    longint unsigned mag;
    logic [31:0] t;
    mag = (x < 0) ? longint'(-x) : longint'(x);
    t = 32'((mag << 31) / 64'd1800000000);
    return (x < 0) ? -t : t;
  endfunction

  function automatic void cordic_sincos(input logic [31:0] ang, output longint c,
                                        output longint s);
    logic flip;
    longint x, y, z, nx;
    flip = ((ang + 32'h4000_0000) & 32'h8000_0000) != 0;
    x = 652032874;
    y = 0;
    if (flip) ang = ang + 32'h8000_0000;
    z = longint'({32'b0, ang ^ 32'h8000_0000}) - 64'sd2147483648;
    for (int i = 0; i < STAGES && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_lut[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_lut[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // vectoring pass: half the central angle in turn units, clamped
  function automatic longint half_central_angle(longint y, longint x);
    longint z, nx;
    z = 0;
    for (int i = 0; i < STAGES && i < 32; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_lut[i];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_lut[i];
      end
      x = nx;
    end
    if (z < 0) z = 0;
    if (z > Q30) z = Q30;
    return z;
  endfunction

  function automatic logic [34:0] predict_distance(logic [1:0] op, logic signed [30:0] lat1,
      logic signed [31:0] lon1, logic signed [30:0] lat2, logic signed [31:0] lon2);
    logic [31:0] t1, g1, t2, g2;
    longint c, s, c1, c2, sl, lat_term, lon_term, a, z;
    longint unsigned t, th, tl, hi, d;
    t1 = deg_to_turn(longint'(lat1));
    g1 = deg_to_turn(longint'(lon1));
    t2 = deg_to_turn(longint'(lat2));
    g2 = deg_to_turn(longint'(lon2));
    cordic_sincos((t2 - t1) >> 1, c, s);
    lat_term = (s * s) >>> 30;
    cordic_sincos(t1, c1, s);
    cordic_sincos(t2, c2, s);
    cordic_sincos((g2 - g1) >> 1, c, sl);
    lon_term = (((c1 * c2) >>> 30) * ((sl * sl) >>> 30)) >>> 30;
    if (op == OP_LAT) a = lat_term;
    else if (op == OP_LON) a = lon_term;
    else a = lat_term + lon_term;
    // a negative cosine product may drive a below zero
    if (a < 0) a = 0;
    if (a > Q30) a = Q30;
    z = half_central_angle(longint'(floor_sqrt(longint'(a) << 30)),
                           longint'(floor_sqrt(longint'(Q30 - a) << 30)));
    t = longint'(z) * 64'd6588397317;
    th = t >> 32;
    tl = t & 64'hFFFF_FFFF;
    hi = th * radius_m + ((tl * radius_m) >> 32);
    d = hi >> 19;
    if (d > 64'd34359738367) d = 64'd34359738367;
    return 35'(d);
  endfunction

  task automatic report_mismatch(string what);
    error_count++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // check each result word against the oldest predicted distance
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (distance_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected word, distance_mm=%0d", out_distance_mm));
      end else begin
        if (out_distance_mm !== distance_queue[0])
          report_mismatch($sformatf("distance_mm got %0d, want %0d",
                                    out_distance_mm, distance_queue[0]));
        void'(distance_queue.pop_front());
        words_checked++;
      end
    end
  end

  // end the run if nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles", idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // hold one word until the block takes it, predict it, then maybe idle
  task automatic send_word(logic [1:0] op, logic signed [30:0] lat1, logic signed [31:0] lon1,
                           logic signed [30:0] lat2, logic signed [31:0] lon2);
    start <= 1'b1;
    in_op <= op;
    in_first_lat <= lat1;
    in_first_lon <= lon1;
    in_second_lat <= lat2;
    in_second_lon <= lon2;
    @(posedge clk);
    while (busy) @(posedge clk);
    distance_queue.push_back(predict_distance(op, lat1, lon1, lat2, lon2));
    words_sent++;
    // idle each cycle with the given chance
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // drop start, let every word in flight drain, then allow a pipeline's worth more
  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (distance_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_radius(logic [23:0] value);
    drain_pipeline();
    cfg_valid <= 1'b1;
    cfg_sphere_radius_m <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    radius_m = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    idle_pct = 0;
    // extremes of each field and identical points
    send_word(OP_FULL, 0, 0, 0, 0);
    send_word(OP_FULL, -900000000, -1800000000, 900000000, 1800000000);
    send_word(OP_FULL, 900000000, 0, -900000000, 0);
    send_word(OP_FULL, 0, -1800000000, 0, 1800000000);
    send_word(OP_FULL, 0, 0, 0, 1800000000);
    send_word(OP_LAT, -900000000, 123456789, 900000000, -55);
    send_word(OP_LON, 0, -1800000000, 0, 0);
    send_word(OP_LON, 900000000, 0, 900000000, 1800000000);
    send_word(OP_LAT, 10, 10, 11, 11);
    // spare op code must match full distance
    send_word(OP_SPARE, 515000000, -1270000, 407000000, -740000000);
    send_word(OP_FULL, 515000000, -1270000, 407000000, -740000000);
    // raw bit patterns beyond the legal range, angles wrap
    send_word(OP_FULL, 31'h3FFF_FFFF, 32'h7FFF_FFFF, 31'h4000_0000, 32'h8000_0000);
    send_word(OP_LON, 31'h3FFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'h0000_0001);
    // latitude past the pole: cosine product negative, a clamps to zero
    send_word(OP_LON, 1000000000, 0, 0, 1800000000);
    send_word(OP_FULL, 1000000000, 0, 1000000000, 1000000000);
    send_word(OP_LAT, -31'sd1, -32'sd1, 31'sd1, 32'sd1);
    drain_pipeline();
  endtask

  task automatic test_radius_extremes();
    write_radius(24'hFF_FFFF);
    idle_pct = 29;
    // antipodes with the largest sphere push distance into saturation
    send_word(OP_FULL, 0, 0, 0, 1800000000);
    send_word(OP_LAT, -900000000, 0, 900000000, 0);
    send_word(OP_FULL, 100000000, 200000000, -300000000, -1600000000);
    write_radius(24'd0);
    send_word(OP_FULL, 0, 0, 0, 1800000000);
    send_word(OP_LON, 300000000, 0, 0, 900000000);
    write_radius(24'd1);
    send_word(OP_FULL, 0, 0, 0, 1800000000);
    send_word(OP_FULL, 0, 0, 1, 1);
    drain_pipeline();
  endtask

  function automatic logic signed [30:0] pick_lat();
    if ($urandom_range(9) == 0) return 31'($urandom);
    return 31'(longint'($urandom_range(1800000000)) - 900000000);
  endfunction

  function automatic logic signed [31:0] pick_lon();
    if ($urandom_range(9) == 0) return 32'($urandom);
    return 32'(longint'($urandom_range(32'd3600000000)) - 1800000000);
  endfunction

  task automatic test_random(int count, int pct);
    logic signed [30:0] lat1, lat2;
    logic signed [31:0] lon1, lon2;
    logic [1:0] op;
    idle_pct = pct;
    for (int n = 0; n < count; n++) begin
      op = 2'($urandom_range(3));
      lat1 = pick_lat();
      lon1 = pick_lon();
      if ($urandom_range(3) == 0) begin
        // nearby track points: small deltas
        lat2 = lat1 + 31'($signed($urandom_range(20000)) - 10000);
        lon2 = lon1 + 32'($signed($urandom_range(20000)) - 10000);
      end else begin
        lat2 = pick_lat();
        lon2 = pick_lon();
      end
      send_word(op, lat1, lon1, lat2, lon2);
    end
    drain_pipeline();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_radius_extremes();
    write_radius(24'd6378137);
    test_random(240, 29);
    write_radius(24'($urandom_range(1, 24'hFF_FFFF)));
    test_random(240, 76);
    write_radius(24'($urandom_range(6000000, 7000000)));
    test_random(240, 0);
    drain_pipeline();
    $display("covered %0d words (%0d checked), all ops, radius 0/1/max/random",
             words_sent, words_checked);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/gcd_pkg.sv
rtl/great_circle_distance_core.sv
test/tb_great_circle_distance_core.sv
